@@ design/md64_pkg.sv @@
// Shared constants and types for the 64-bit multiply-divide block.
package md64_pkg;
  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;
  // one division cell per bit of the 128-bit dividend
  localparam int unsigned Cells = 2 * WordW;

  // state carried from one divider cell to the next
  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] rem;
    logic [WordW-1:0] lo;
    logic [WordW-1:0] den;
    logic [WordW-1:0] quo;
    logic             dbz;
    logic             ovf;
  } div_stage_t;
endpackage

@@ design/multiply_divide_64.sv @@
// Top level: pipelined 128-bit product divided by a 64-bit divisor.
// Channel | signals                                   | direction
// request | valid stall multiplicand multiplier divisor | in
// result  | out_valid out_stall quotient flags           | out
// One request per cycle while the output is not stalled; 2 multiplier stages, 128 division
// cells and an output register. The 128-bit dividend runs through 128 restoring
// cells starting from a zero remainder, so the remainder stays below 2^64.
// Synchronous reset empties the pipeline. A stall at the output freezes the
// whole chain; the chain moves whenever the output register is empty or taken.
module multiply_divide_64 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid,
  output logic                       stall,
  input  logic [md64_pkg::WordW-1:0] multiplicand,
  input  logic [md64_pkg::WordW-1:0] multiplier,
  input  logic [md64_pkg::WordW-1:0] divisor,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [md64_pkg::WordW-1:0] quotient,
  output logic                       divide_by_zero,
  output logic                       quotient_overflow
);
  localparam int unsigned W = md64_pkg::WordW;
  localparam int unsigned CELLS = md64_pkg::Cells;

  md64_pkg::div_stage_t mstage, pre;
  md64_pkg::div_stage_t chain [CELLS+1];
  logic advance;

  assign advance = !out_valid || !out_stall;
  assign stall   = !advance;

  md64_mult u_mult (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(valid),
    .a(multiplicand), .b(multiplier), .c(divisor), .out_stage(mstage)
  );

  // feed the full 128-bit dividend: high word enters through lo stream first
  always_comb begin
    pre     = mstage;
    pre.rem = '0;
    pre.lo  = mstage.rem;
    pre.quo = mstage.lo;
  end
  assign chain[0] = pre;

  // cells 0..W-1 consume the high word; then the low word (kept in quo) moves
  // into lo for the remaining cells
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    md64_pkg::div_stage_t cin;
    always_comb begin
      cin = chain[i];
      if (i == W) begin
        cin.lo  = chain[i].quo;
        cin.quo = '0;
      end
    end
    md64_cell #(.HIGH_WORD(i < W)) u_cell (
      .clk(clk), .rst(rst), .advance(advance),
      .in_stage(i < W ? chain[i] : cin), .out_stage(chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= chain[CELLS].valid;
    if (advance) begin
      quotient          <= chain[CELLS].dbz ? '0 : chain[CELLS].quo;
      divide_by_zero    <= chain[CELLS].dbz;
      quotient_overflow <= chain[CELLS].ovf;
    end
  end
endmodule

@@ design/md64_mult.sv @@
// Two-stage 64x64 multiplier built from four 32x32 partial products.
module md64_mult (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic                           in_valid,
  input  logic [md64_pkg::WordW-1:0]     a,
  input  logic [md64_pkg::WordW-1:0]     b,
  input  logic [md64_pkg::WordW-1:0]     c,
  output md64_pkg::div_stage_t           out_stage
);
  localparam int unsigned W = md64_pkg::WordW;
  localparam int unsigned H = md64_pkg::HalfW;

  logic [W-1:0] ll, lh, hl, hh;
  logic [W-1:0] den1;
  logic         valid1;
  logic [2*W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      out_stage.valid <= 1'b0;
    end else if (advance) begin
      valid1 <= in_valid;
      out_stage.valid <= valid1;
    end
    if (advance) begin
      ll   <= a[H-1:0] * b[H-1:0];
      lh   <= a[H-1:0] * b[W-1:H];
      hl   <= a[W-1:H] * b[H-1:0];
      hh   <= a[W-1:H] * b[W-1:H];
      den1 <= c;
      out_stage.rem <= prod[2*W-1:W];
      out_stage.lo  <= prod[W-1:0];
      out_stage.den <= den1;
      out_stage.quo <= '0;
      out_stage.dbz <= (den1 == '0);
      out_stage.ovf <= (den1 != '0) && (prod[2*W-1:W] >= den1);
    end
  end

  always_comb begin
    prod = {hh, ll} + {{H{1'b0}}, lh, {H{1'b0}}} + {{H{1'b0}}, hl, {H{1'b0}}};
  end
endmodule

@@ design/md64_cell.sv @@
// Restoring cell; one quotient bit per unstalled cycle in the low word.
module md64_cell #(
  parameter bit HIGH_WORD = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  md64_pkg::div_stage_t in_stage,
  output md64_pkg::div_stage_t out_stage
);
  localparam int unsigned W = md64_pkg::WordW;

  logic [W-1:0] rem_in;
  logic [W:0]   shifted;
  logic [W:0]   diff;
  logic         take;

  always_comb begin
    // remainder stays below den, so the 65-bit difference sign decides
    rem_in  = in_stage.rem;
    shifted = {rem_in, in_stage.lo[W-1]};
    diff    = shifted - {1'b0, in_stage.den};
    take    = !diff[W];
  end

  always_ff @(posedge clk) begin
    if (rst) out_stage.valid <= 1'b0;
    else if (advance) out_stage.valid <= in_stage.valid;
    if (advance) begin
      out_stage.rem <= take ? diff[W-1:0] : shifted[W-1:0];
      out_stage.lo  <= {in_stage.lo[W-2:0], 1'b0};
      out_stage.den <= in_stage.den;
      // high-word cells only reduce the remainder; quo carries the low
      // dividend word through untouched (overflow is already known)
      out_stage.quo <= HIGH_WORD ? in_stage.quo : {in_stage.quo[W-2:0], take};
      out_stage.dbz <= in_stage.dbz;
      out_stage.ovf <= in_stage.ovf;
    end
  end
endmodule

@@ tb/multiply_divide_64_checker.sv @@
// Checker for multiply_divide_64: predicts each result and compares it.
`timescale 1ns / 1ps
module multiply_divide_64_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  input  logic        stall,
  input  logic [63:0] multiplicand,
  input  logic [63:0] multiplier,
  input  logic [63:0] divisor,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] quotient,
  input  logic        divide_by_zero,
  input  logic        quotient_overflow,
  output int          errors,
  output int          pending
);
  typedef struct packed {
    logic [63:0] quo;
    logic        dbz;
    logic        ovf;
  } scaled_t;

  scaled_t scaled_q[$];

  function automatic scaled_t scale(logic [63:0] a, logic [63:0] b, logic [63:0] c);
    scaled_t r;
    logic [127:0] prod;
    logic [127:0] full;
    r = '0;
    if (c == 0) begin
      r.dbz = 1'b1;
    end else begin
      prod = {64'd0, a} * {64'd0, b};
      full = prod / {64'd0, c};
      r.quo = full[63:0];
      r.ovf = |full[127:64];
    end
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  assign pending = scaled_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    scaled_t e;
    if (!rst) begin
      if (valid && !stall) scaled_q.push_back(scale(multiplicand, multiplier, divisor));
      if (out_valid && !out_stall) begin
        if (scaled_q.size() == 0) begin
          report("unexpected result", quotient, 64'd0);
        end else begin
          e = scaled_q.pop_front();
          if (quotient !== e.quo) report("quotient", quotient, e.quo);
          if (divide_by_zero !== e.dbz) report("divide_by_zero", divide_by_zero, e.dbz);
          if (quotient_overflow !== e.ovf)
            report("quotient_overflow", quotient_overflow, e.ovf);
        end
      end
    end
  end
endmodule

@@ tb/multiply_divide_64_tb.sv @@
// Testbench top for multiply_divide_64: stimulus, idling and verdict.
`timescale 1ns / 1ps
module multiply_divide_64_tb;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        stall;
  logic [63:0] multiplicand = '0;
  logic [63:0] multiplier = '0;
  logic [63:0] divisor = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] quotient;
  logic        divide_by_zero;
  logic        quotient_overflow;
  int          errors;
  int          pending;
  int          send_idle = 0;
  int          recv_idle = 0;

  localparam logic [63:0] Ones = '1;
  localparam logic [63:0] Top = 64'h8000_0000_0000_0000;

  always #4 clk = ~clk;

  multiply_divide_64 dut (
    .clk, .rst, .valid, .stall, .multiplicand, .multiplier, .divisor,
    .out_valid, .out_stall, .quotient, .divide_by_zero, .quotient_overflow
  );

  multiply_divide_64_checker chk (
    .clk, .rst, .valid, .stall, .multiplicand, .multiplier, .divisor,
    .out_valid, .out_stall, .quotient, .divide_by_zero, .quotient_overflow,
    .errors, .pending
  );

  // receiver stalls at random
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(5))
      0: w = w >> $urandom_range(63);
      1: w = Ones;
      2: w = w & 64'hFFFF;
      default: ;
    endcase
    return w;
  endfunction

  // present one request, hold it until accepted
  task automatic send_request(logic [63:0] a, logic [63:0] b, logic [63:0] c);
    while ($urandom_range(99) < send_idle) begin
      valid <= 1'b0;
      @(posedge clk);
    end
    valid <= 1'b1;
    multiplicand <= a;
    multiplier <= b;
    divisor <= c;
    do @(posedge clk); while (stall);
  endtask

  task automatic send_random();
    logic [63:0] c;
    c = rand_word();
    if ($urandom_range(19) == 0) c = '0;
    else if ($urandom_range(3) == 0) c = Ones >> $urandom_range(63);
    send_request(rand_word(), rand_word(), c);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_request(64'd0, 64'd0, 64'd1);
    send_request(Ones, Ones, Ones);
    send_request(Ones, Ones, 64'd1);
    send_request(Ones, Ones, 64'd0);
    send_request(64'd0, 64'd0, 64'd0);
    send_request(Ones, 64'd1, 64'd1);
    send_request(Ones, 64'd2, 64'd1);
    send_request(Ones, 64'd2, 64'd2);
    send_request(Top, 64'd2, Ones);
    send_request(Ones, Ones, Top);
    send_request(Ones, Ones, Top - 64'd1);
    send_request(Top, Top, Top);
    send_request(64'd12345, 64'd678, 64'd7);
    send_request(Ones, 64'd0, 64'd3);
    send_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'h1_0000_0000);
    send_request(Ones, Ones, 64'h1_0000_0000);
    send_idle = 29; recv_idle = 83;
    repeat (270) send_random();
    send_idle = 83; recv_idle = 29;
    repeat (270) send_random();
    send_idle = 0; recv_idle = 0;
    repeat (270) send_random();
    valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("[multiply_divide_64] OK");
    else $display("[multiply_divide_64] ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("[multiply_divide_64] ERROR");
    $finish;
  end
endmodule
